>>> design/phf_pkg.sv
// Package for the pcapng HCI packet framer: request/response payload types,
// command and register codes, and the sequencer program ROM.
// Used by pcapng_hci_packet_framer; depends on nothing else.
package phf_pkg;

   // Command codes carried in the func field.
   localparam logic [1:0] FUNC_FILE_HDR = 2'd0;
   localparam logic [1:0] FUNC_START    = 2'd1;
   localparam logic [1:0] FUNC_PAYLOAD  = 2'd2;

   // Configuration register indexes.
   localparam logic CSR_LINK_TYPE   = 1'b0;
   localparam logic CSR_SNAP_LENGTH = 1'b1;

   localparam logic [15:0] LINK_TYPE_RESET   = 16'd187;
   localparam logic [31:0] SNAP_LENGTH_RESET = 32'd0;

   // Enhanced packet block bytes outside the padded data: 28 header + 4 trailer.
   localparam int EPB_OVERHEAD = 32;

   typedef struct packed {
      logic [1:0]  func;
      logic [7:0]  h4_kind;
      logic [10:0] payload_len;
      logic [7:0]  data_byte;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       block_end;
      logic       run_last;
   } rsp_payload_type;

   // Byte source for one step of the program.
   typedef enum logic [4:0] {
      SRC_CONST,
      SRC_LINK_LO,
      SRC_LINK_HI,
      SRC_SNAP0,
      SRC_SNAP1,
      SRC_SNAP2,
      SRC_SNAP3,
      SRC_BLEN0,
      SRC_BLEN1,
      SRC_BLEN2,
      SRC_BLEN3,
      SRC_TOT0,
      SRC_TOT1,
      SRC_TOT2,
      SRC_TOT3,
      SRC_KIND,
      SRC_DATA
   } src_type;

   // What the sequencer does after the step.
   typedef enum logic [1:0] {
      SEQ_NEXT,        // go to the following step
      SEQ_DONE,        // last byte of this request
      SEQ_FIN_IF_EMPTY,// payload complete: enter padding/trailer, else done
      SEQ_PAD_LOOP     // repeat while pad bytes remain
   } seq_type;

   typedef struct packed {
      src_type    src;
      logic [7:0] const_byte;
      logic       block_end;
      seq_type    seq;
   } ctrl_type;

   localparam int PC_W = 7;

   localparam logic [PC_W-1:0] PC_SHB   = 7'd0;
   localparam logic [PC_W-1:0] PC_EPB   = 7'd48;
   localparam logic [PC_W-1:0] PC_DATA  = 7'd77;
   localparam logic [PC_W-1:0] PC_PAD   = 7'd78;
   localparam logic [PC_W-1:0] PC_TRAIL = 7'd79;

   function automatic ctrl_type cw(src_type src, logic [7:0] cb, logic be, seq_type seq);
      ctrl_type c;
      c.src        = src;
      c.const_byte = cb;
      c.block_end  = be;
      c.seq        = seq;
      return c;
   endfunction

   // Program ROM. Steps not listed emit a zero constant and fall through.
   function automatic ctrl_type rom(logic [PC_W-1:0] pc);
      ctrl_type c;
      c = cw(SRC_CONST, 8'h00, 1'b0, SEQ_NEXT);
      unique case (pc)
         // Section header block.
         7'd0, 7'd3:                   c = cw(SRC_CONST, 8'h0A, 1'b0, SEQ_NEXT);
         7'd1, 7'd2:                   c = cw(SRC_CONST, 8'h0D, 1'b0, SEQ_NEXT);
         7'd4, 7'd24:                  c = cw(SRC_CONST, 8'h1C, 1'b0, SEQ_NEXT);
         7'd8:                         c = cw(SRC_CONST, 8'h4D, 1'b0, SEQ_NEXT);
         7'd9:                         c = cw(SRC_CONST, 8'h3C, 1'b0, SEQ_NEXT);
         7'd10:                        c = cw(SRC_CONST, 8'h2B, 1'b0, SEQ_NEXT);
         7'd11:                        c = cw(SRC_CONST, 8'h1A, 1'b0, SEQ_NEXT);
         7'd12:                        c = cw(SRC_CONST, 8'h01, 1'b0, SEQ_NEXT);
         7'd20, 7'd21, 7'd22, 7'd23:   c = cw(SRC_CONST, 8'hFF, 1'b0, SEQ_NEXT);
         7'd27:                        c = cw(SRC_CONST, 8'h00, 1'b1, SEQ_NEXT);
         // Interface description block.
         7'd28:                        c = cw(SRC_CONST, 8'h01, 1'b0, SEQ_NEXT);
         7'd32, 7'd44:                 c = cw(SRC_CONST, 8'h14, 1'b0, SEQ_NEXT);
         7'd36:                        c = cw(SRC_LINK_LO, 8'h00, 1'b0, SEQ_NEXT);
         7'd37:                        c = cw(SRC_LINK_HI, 8'h00, 1'b0, SEQ_NEXT);
         7'd40:                        c = cw(SRC_SNAP0, 8'h00, 1'b0, SEQ_NEXT);
         7'd41:                        c = cw(SRC_SNAP1, 8'h00, 1'b0, SEQ_NEXT);
         7'd42:                        c = cw(SRC_SNAP2, 8'h00, 1'b0, SEQ_NEXT);
         7'd43:                        c = cw(SRC_SNAP3, 8'h00, 1'b0, SEQ_NEXT);
         7'd47:                        c = cw(SRC_CONST, 8'h00, 1'b1, SEQ_DONE);
         // Enhanced packet block header and H4 type byte.
         7'd48:                        c = cw(SRC_CONST, 8'h06, 1'b0, SEQ_NEXT);
         7'd52, 7'd79:                 c = cw(SRC_BLEN0, 8'h00, 1'b0, SEQ_NEXT);
         7'd53, 7'd80:                 c = cw(SRC_BLEN1, 8'h00, 1'b0, SEQ_NEXT);
         7'd54, 7'd81:                 c = cw(SRC_BLEN2, 8'h00, 1'b0, SEQ_NEXT);
         7'd55:                        c = cw(SRC_BLEN3, 8'h00, 1'b0, SEQ_NEXT);
         7'd68, 7'd72:                 c = cw(SRC_TOT0, 8'h00, 1'b0, SEQ_NEXT);
         7'd69, 7'd73:                 c = cw(SRC_TOT1, 8'h00, 1'b0, SEQ_NEXT);
         7'd70, 7'd74:                 c = cw(SRC_TOT2, 8'h00, 1'b0, SEQ_NEXT);
         7'd71, 7'd75:                 c = cw(SRC_TOT3, 8'h00, 1'b0, SEQ_NEXT);
         7'd76:                        c = cw(SRC_KIND, 8'h00, 1'b0, SEQ_FIN_IF_EMPTY);
         // Payload byte.
         7'd77:                        c = cw(SRC_DATA, 8'h00, 1'b0, SEQ_FIN_IF_EMPTY);
         // Padding, then the repeated block length.
         7'd78:                        c = cw(SRC_CONST, 8'h00, 1'b0, SEQ_PAD_LOOP);
         7'd82:                        c = cw(SRC_BLEN3, 8'h00, 1'b1, SEQ_DONE);
         default:                      c = cw(SRC_CONST, 8'h00, 1'b0, SEQ_NEXT);
      endcase
      return c;
   endfunction

endpackage

>>> design/pcapng_hci_packet_framer.sv
// A request sets running and pc; its first byte then goes to the output register.
// Throughput: one stream byte per cycle from the program ROM sequencer; a request holds
// the input until its bytes are out (48 for a file header, 29 or 36 for a start,
// 1 or 5 to 8 for a payload byte, none for a dropped request); output stalls pause it.
// Reset (synchronous, active high) closes any packet, restores link_type 187 and
// snap_length 0, and leaves the sequencer idle. Depends on phf_pkg.
module pcapng_hci_packet_framer #(
   parameter int MAX_PAYLOAD = 1024
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  phf_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output phf_pkg::rsp_payload_type rsp_payload,
   input  logic                     csr_write_enable,
   input  logic                     csr_index,
   input  logic [31:0]              csr_wdata
);

   // The 11-bit length field caps what saturation can ever yield.
   localparam int SatMax = (MAX_PAYLOAD > 2047) ? 2047 : MAX_PAYLOAD;
   localparam int CntW   = $clog2(SatMax + 1);
   localparam int TotW   = $clog2(SatMax + phf_pkg::EPB_OVERHEAD + 5);

   logic [15:0]                link_type_ff, link_type_in;
   logic [31:0]                snap_length_ff, snap_length_in;
   logic                       packet_open_ff, packet_open_in;
   logic [CntW-1:0]            bytes_left_ff, bytes_left_in;
   logic [TotW-1:0]            total_ff, total_in;
   logic [TotW-1:0]            blen_ff, blen_in;
   logic [1:0]                 pad_ff, pad_in;
   logic [1:0]                 pad_cnt_ff, pad_cnt_in;
   logic [7:0]                 kind_ff, kind_in;
   logic [7:0]                 data_ff, data_in;
   logic                       running_ff, running_in;
   logic [phf_pkg::PC_W-1:0]   pc_ff, pc_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   phf_pkg::rsp_payload_type   rsp_payload_ff, rsp_payload_in;

   phf_pkg::ctrl_type          ctrl;
   logic                       req_accept;
   logic                       step;
   logic                       last;
   logic [7:0]                 sel_byte;
   logic [31:0]                blen_word;
   logic [31:0]                tot_word;
   logic [CntW-1:0]            plen_sat;
   logic [TotW-1:0]            start_total;
   logic [TotW-1:0]            start_padded;

   assign req_stall   = running_ff;
   assign req_accept  = req_valid && !running_ff;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   assign ctrl      = phf_pkg::rom(pc_ff);
   assign step      = running_ff && (!rsp_valid_ff || !rsp_stall);
   assign blen_word = 32'(blen_ff);
   assign tot_word  = 32'(total_ff);

   // Length of a new packet: saturate, add the H4 byte, round up to a word.
   always_comb begin
      if (32'(req_payload.payload_len) > MAX_PAYLOAD) begin
         plen_sat = CntW'(SatMax);
      end else begin
         plen_sat = CntW'(req_payload.payload_len);
      end
      start_total  = TotW'(plen_sat) + TotW'(1);
      start_padded = (start_total + TotW'(3)) & ~TotW'(3);
   end

   always_comb begin
      unique case (ctrl.src)
         phf_pkg::SRC_CONST:   sel_byte = ctrl.const_byte;
         phf_pkg::SRC_LINK_LO: sel_byte = link_type_ff[7:0];
         phf_pkg::SRC_LINK_HI: sel_byte = link_type_ff[15:8];
         phf_pkg::SRC_SNAP0:   sel_byte = snap_length_ff[7:0];
         phf_pkg::SRC_SNAP1:   sel_byte = snap_length_ff[15:8];
         phf_pkg::SRC_SNAP2:   sel_byte = snap_length_ff[23:16];
         phf_pkg::SRC_SNAP3:   sel_byte = snap_length_ff[31:24];
         phf_pkg::SRC_BLEN0:   sel_byte = blen_word[7:0];
         phf_pkg::SRC_BLEN1:   sel_byte = blen_word[15:8];
         phf_pkg::SRC_BLEN2:   sel_byte = blen_word[23:16];
         phf_pkg::SRC_BLEN3:   sel_byte = blen_word[31:24];
         phf_pkg::SRC_TOT0:    sel_byte = tot_word[7:0];
         phf_pkg::SRC_TOT1:    sel_byte = tot_word[15:8];
         phf_pkg::SRC_TOT2:    sel_byte = tot_word[23:16];
         phf_pkg::SRC_TOT3:    sel_byte = tot_word[31:24];
         phf_pkg::SRC_KIND:    sel_byte = kind_ff;
         phf_pkg::SRC_DATA:    sel_byte = data_ff;
         default:              sel_byte = 8'h00;
      endcase
   end

   always_comb begin
      link_type_in   = link_type_ff;
      snap_length_in = snap_length_ff;
      packet_open_in = packet_open_ff;
      bytes_left_in  = bytes_left_ff;
      total_in       = total_ff;
      blen_in        = blen_ff;
      pad_in         = pad_ff;
      pad_cnt_in     = pad_cnt_ff;
      kind_in        = kind_ff;
      data_in        = data_ff;
      running_in     = running_ff;
      pc_in          = pc_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      last           = 1'b0;

      if (csr_write_enable) begin
         unique case (csr_index)
            phf_pkg::CSR_LINK_TYPE:   link_type_in   = csr_wdata[15:0];
            phf_pkg::CSR_SNAP_LENGTH: snap_length_in = csr_wdata;
            default:                  link_type_in   = link_type_ff;
         endcase
      end

      if (req_accept) begin
         priority if (req_payload.func == phf_pkg::FUNC_FILE_HDR) begin
            running_in = 1'b1;
            pc_in      = phf_pkg::PC_SHB;
         end else if (req_payload.func == phf_pkg::FUNC_START) begin
            running_in     = 1'b1;
            pc_in          = phf_pkg::PC_EPB;
            kind_in        = req_payload.h4_kind;
            bytes_left_in  = plen_sat;
            packet_open_in = (plen_sat != '0);
            total_in       = start_total;
            blen_in        = start_padded + TotW'(phf_pkg::EPB_OVERHEAD);
            pad_in         = 2'(start_padded - start_total);
         end else if (req_payload.func == phf_pkg::FUNC_PAYLOAD && packet_open_ff
                      && bytes_left_ff != '0) begin
            running_in     = 1'b1;
            pc_in          = phf_pkg::PC_DATA;
            data_in        = req_payload.data_byte;
            bytes_left_in  = bytes_left_ff - CntW'(1);
            packet_open_in = (bytes_left_ff != CntW'(1));
         end else begin
            // Unused command or payload byte outside a packet: no output.
            running_in = 1'b0;
         end
      end

      if (step) begin
         unique case (ctrl.seq)
            phf_pkg::SEQ_NEXT: begin
               pc_in = pc_ff + 1'b1;
            end
            phf_pkg::SEQ_DONE: begin
               running_in = 1'b0;
               last       = 1'b1;
            end
            phf_pkg::SEQ_FIN_IF_EMPTY: begin
               if (bytes_left_ff == '0) begin
                  pc_in      = (pad_ff != 2'd0) ? phf_pkg::PC_PAD : phf_pkg::PC_TRAIL;
                  pad_cnt_in = pad_ff;
               end else begin
                  running_in = 1'b0;
                  last       = 1'b1;
               end
            end
            phf_pkg::SEQ_PAD_LOOP: begin
               pad_cnt_in = pad_cnt_ff - 2'd1;
               if (pad_cnt_ff <= 2'd1) begin
                  pc_in = pc_ff + 1'b1;
               end
            end
            default: begin
               running_in = 1'b0;
            end
         endcase
         rsp_valid_in             = 1'b1;
         rsp_payload_in.out_byte  = sel_byte;
         rsp_payload_in.block_end = ctrl.block_end;
         rsp_payload_in.run_last  = last;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_type_ff   <= phf_pkg::LINK_TYPE_RESET;
         snap_length_ff <= phf_pkg::SNAP_LENGTH_RESET;
         packet_open_ff <= 1'b0;
         bytes_left_ff  <= '0;
         total_ff       <= '0;
         running_ff     <= 1'b0;
         pc_ff          <= phf_pkg::PC_SHB;
         rsp_valid_ff   <= 1'b0;
      end else begin
         link_type_ff   <= link_type_in;
         snap_length_ff <= snap_length_in;
         packet_open_ff <= packet_open_in;
         bytes_left_ff  <= bytes_left_in;
         total_ff       <= total_in;
         running_ff     <= running_in;
         pc_ff          <= pc_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      blen_ff        <= blen_in;
      pad_ff         <= pad_in;
      pad_cnt_ff     <= pad_cnt_in;
      kind_ff        <= kind_in;
      data_ff        <= data_in;
      rsp_payload_ff <= rsp_payload_in;
   end

endmodule
